// ===== sv/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg: shared types, constants and the character classifier
// Holds the group type that passes from the front end to the back end and
// the status and sextet codes.
// ----------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

  // Status codes carried on the final result of a string
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CHAR = 2'd1;
  localparam logic [1:0] ST_BAD_LEN  = 2'd2;

  // Classifier codes: 0..63 are sextet values
  localparam logic [6:0] SX_PAD = 7'd64;
  localparam logic [6:0] SX_BAD = 7'd65;

  // Alphabet offsets
  localparam logic [7:0] LOWER_BASE = 8'd26;
  localparam logic [7:0] DIGIT_BASE = 8'd52;
  localparam logic [6:0] SX_62      = 7'd62;
  localparam logic [6:0] SX_63      = 7'd63;

  // One group of results: up to three items produced by one input item
  typedef struct packed {
    logic [2:0][7:0] bytes;     // bytes[0] goes out first
    logic [1:0]      last_idx;  // index of the last item in the group
    logic            has_data;  // byte_valid of every item in the group
    logic [1:0]      status;    // status of the last item
    logic            is_final;  // last item closes the string
  } group_t;

  // Head of the group queue as seen by the back end
  typedef struct packed {
    logic   valid;
    group_t grp;
  } head_t;

  // Map a character code onto its sextet, the pad code or the bad code
  function automatic logic [6:0] b64d_sextet(input logic [7:0] ch);
    logic [6:0] sx;
    sx = SX_BAD;
    case (ch) inside
      [8'h41:8'h5A]: sx = 7'(ch - 8'h41);               // A-Z
      [8'h61:8'h7A]: sx = 7'(ch - 8'h61 + LOWER_BASE);  // a-z
      [8'h30:8'h39]: sx = 7'(ch - 8'h30 + DIGIT_BASE);  // 0-9
      8'h2B, 8'h2D:  sx = SX_62;                        // + or -
      8'h2F, 8'h5F:  sx = SX_63;                        // / or _
      8'h3D:         sx = SX_PAD;                       // =
      default:       sx = SX_BAD;
    endcase
    return sx;
  endfunction

endpackage

`default_nettype wire

// ===== sv/b64d_if.sv =====
// ----------------------------------------------------------------------------
// b64d_in_if / b64d_out_if: valid/ready channels of the decoder
// Input carries one character per item, output one decoded result per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic [1:0] status;
  logic       final_result;

  modport source (output valid, output data_byte, output byte_valid,
                  output status, output final_result, input ready);
  modport sink   (input valid, input data_byte, input byte_valid,
                  input status, input final_result, output ready);
endinterface

`default_nettype wire

// ===== sv/b64d_front.sv =====
// ----------------------------------------------------------------------------
// b64d_front: character intake and sextet accumulation
// Classifies each character, collects sextets and pushes one group of
// results into the queue whenever an item produces output.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_front (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  b64d_in_if.sink               in_i,
  input  wire                   full_i,
  output logic                  push_o,
  output b64d_pkg::group_t      grp_o
);
  import b64d_pkg::*;

  logic [17:0] acc_q, acc_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        bad_q, bad_d;

  logic [6:0]  sx;
  logic        accept, is_bad, is_data, bad_now, grp_done;
  logic [23:0] word;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;

  // Classification
  assign sx       = b64d_sextet(in_i.char_code);
  assign is_bad   = (sx == SX_BAD);
  assign is_data  = !sx[6];
  assign bad_now  = bad_q || is_bad;
  assign grp_done = !bad_now && is_data && (cnt_q == 2'd3);
  assign word     = {acc_q[17:0], sx[5:0]};

  // Accumulator update and group build
  always_comb begin
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    bad_d  = bad_q;
    push_o = 1'b0;
    grp_o  = '0;
    grp_o.status = ST_OK;
    if (accept) begin
      if (is_bad) begin
        bad_d = 1'b1;
      end
      if (grp_done) begin
        push_o         = 1'b1;
        grp_o.bytes[0] = word[23:16];
        grp_o.bytes[1] = word[15:8];
        grp_o.bytes[2] = word[7:0];
        grp_o.last_idx = 2'd2;
        grp_o.has_data = 1'b1;
        grp_o.is_final = in_i.end_of_text;
        acc_d          = '0;
        cnt_d          = '0;
      end else if (!bad_now && is_data) begin
        acc_d = {acc_q[11:0], sx[5:0]};
        cnt_d = cnt_q + 2'd1;
      end

      // End of string without a completed group: flush the leftover
      if (in_i.end_of_text && !grp_done) begin
        push_o         = 1'b1;
        grp_o.is_final = 1'b1;
        if (bad_now) begin
          grp_o.status = ST_BAD_CHAR;
        end else begin
          case (cnt_d)
            2'd1: grp_o.status = ST_BAD_LEN;
            2'd2: begin
              grp_o.bytes[0] = acc_d[11:4];
              grp_o.has_data = 1'b1;
            end
            2'd3: begin
              grp_o.bytes[0] = acc_d[17:10];
              grp_o.bytes[1] = acc_d[9:2];
              grp_o.last_idx = 2'd1;
              grp_o.has_data = 1'b1;
            end
            default: grp_o.status = ST_OK;
          endcase
        end
      end

      if (in_i.end_of_text) begin
        acc_d = '0;
        cnt_d = '0;
        bad_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
      bad_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      bad_q <= bad_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/b64d_fifo.sv =====
// ----------------------------------------------------------------------------
// b64d_fifo: short group queue between front and back end
// Holds pending result groups so that intake and output stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_fifo #(
  parameter int DEPTH = 4
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  b64d_pkg::group_t      grp_i,
  output logic                  full_o,
  input  wire                   pop_i,
  output b64d_pkg::head_t       head_o
);
  import b64d_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  group_t        mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == CW'(DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.grp   = mem_q[rd_q];

  // Pointer and fill update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= grp_i;
    end
  end

  // Checks
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("group pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_o.valid)
    else $error("group popped from an empty queue");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("queue fill count out of range");

endmodule

`default_nettype wire

// ===== sv/b64d_back.sv =====
// ----------------------------------------------------------------------------
// b64d_back: result serializer
// Walks the head group one item per cycle, while the output is not stalled,
// into the output register and pops the group after its last item.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_back (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  b64d_pkg::head_t       head_i,
  output logic                  pop_o,
  b64d_out_if.source            out_o
);
  import b64d_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       ov_q, ov_d;
  logic [7:0] data_q, data_d;
  logic       bv_q, bv_d;
  logic [1:0] st_q, st_d;
  logic       fin_q, fin_d;
  logic       load, take, last;

  assign load = !ov_q || out_o.ready;
  assign take = load && head_i.valid;
  assign last = (idx_q == head_i.grp.last_idx);

  // Next output item
  always_comb begin
    idx_d  = idx_q;
    ov_d   = ov_q;
    data_d = data_q;
    bv_d   = bv_q;
    st_d   = st_q;
    fin_d  = fin_q;
    pop_o  = 1'b0;
    if (take) begin
      ov_d   = 1'b1;
      data_d = head_i.grp.bytes[idx_q];
      bv_d   = head_i.grp.has_data;
      st_d   = last ? head_i.grp.status : ST_OK;
      fin_d  = last && head_i.grp.is_final;
      pop_o  = last;
      idx_d  = last ? 2'd0 : idx_q + 2'd1;
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      idx_q <= idx_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    bv_q   <= bv_d;
    st_q   <= st_d;
    fin_q  <= fin_d;
  end

  assign out_o.valid        = ov_q;
  assign out_o.data_byte    = data_q;
  assign out_o.byte_valid   = bv_q;
  assign out_o.status       = st_q;
  assign out_o.final_result = fin_q;

endmodule

`default_nettype wire

// ===== sv/base64url_decoder_top.sv =====
// ----------------------------------------------------------------------------
// base64url_decoder_top: streaming base64 / base64url decoder
// Standard and URL-safe alphabets, pad characters skipped, status on the
// final result of each string.
// ----------------------------------------------------------------------------
//
//   port    dir  item contents
//   in_i    in   char_code[7:0], end_of_text
//   out_o   out  data_byte[7:0], byte_valid, status[1:0], final_result
//
// Intake takes one character per cycle while the group queue has room.
// Output gives one result per cycle while out_o.ready is high, from a registered
// stage; a group of three bytes leaves as three results.
// A character's results pass through the group queue and then the output register.
// Reset clears the accumulator, the queue and the output stage.
// A stalled output fills the queue of FIFO_DEPTH groups, then intake stalls.
`default_nettype none

module base64url_decoder_top #(
  parameter int FIFO_DEPTH = 4
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  b64d_in_if.sink     in_i,
  b64d_out_if.source  out_o
);
  import b64d_pkg::*;

  logic   push, full, pop;
  group_t grp;
  head_t  head;

  b64d_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .grp_o  (grp)
  );

  b64d_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .grp_i  (grp),
    .full_o (full),
    .pop_i  (pop),
    .head_o (head)
  );

  b64d_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

// ===== tb/b64d_decode_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// b64d_decode_checker: decoded-byte predictor and result checker
// Watches the character and result channels of the decoder. Every accepted
// character runs through a local model of the accumulator; the bytes it
// yields are queued and compared in order against the accepted results.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_decode_checker (
  input  wire   clk_i,
  input  wire   rst_ni,
  b64d_in_if    in_i,
  b64d_out_if   out_i,
  output int    mismatch_count_o,
  output int    pending_o
);
  import b64d_pkg::*;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic [1:0] status;
    logic       final_result;
  } dec_result_t;

  // Expected results, oldest first
  dec_result_t decoded_q[$];

  // Local copy of the decoder state
  logic [17:0] sext_acc  = '0;
  logic [1:0]  sext_cnt  = '0;
  logic        bad_seen  = 1'b0;
  int          err_cnt   = 0;

  // Character to sextet, with the pad and bad codes from the package
  function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
    logic [6:0] sx;
    if (c >= 8'h41 && c <= 8'h5A)                   // upper case
      sx = 7'(c - 8'h41);
    else if (c >= 8'h61 && c <= 8'h7A)              // lower case
      sx = 7'(c - 8'h61 + LOWER_BASE);
    else if (c >= 8'h30 && c <= 8'h39)              // digits
      sx = 7'(c - 8'h30 + DIGIT_BASE);
    else if (c == 8'h2B || c == 8'h2D)              // plus, minus
      sx = SX_62;
    else if (c == 8'h2F || c == 8'h5F)              // slash, underscore
      sx = SX_63;
    else if (c == 8'h3D)                            // pad
      sx = SX_PAD;
    else
      sx = SX_BAD;
    return sx;
  endfunction

  function automatic void push_decoded(input logic [7:0] b, input logic vld,
                                       input logic [1:0] st, input logic fin);
    dec_result_t r;
    r.data_byte    = b;
    r.byte_valid   = vld;
    r.status       = st;
    r.final_result = fin;
    decoded_q.insert(decoded_q.size(), r);
  endfunction

  // Advance the local state by one character and queue what it yields
  task automatic decode_char(input logic [7:0] c, input logic eot);
    logic [6:0]  sx;
    logic [23:0] word;
    int          produced;
    produced = 0;
    sx = char_to_sextet(c);
    if (!bad_seen) begin
      if (sx == SX_BAD) begin
        bad_seen = 1'b1;
      end else if (sx != SX_PAD) begin
        if (sext_cnt == 2'd3) begin
          word = {sext_acc, sx[5:0]};
          push_decoded(word[23:16], 1'b1, ST_OK, 1'b0);
          push_decoded(word[15:8], 1'b1, ST_OK, 1'b0);
          push_decoded(word[7:0], 1'b1, ST_OK, eot);
          produced = 3;
          sext_acc = '0;
          sext_cnt = '0;
        end else begin
          sext_acc = {sext_acc[11:0], sx[5:0]};
          sext_cnt = sext_cnt + 2'd1;
        end
      end
    end
    if (eot) begin
      // End of string: flush the leftover or report the status
      if (bad_seen) begin
        push_decoded(8'h00, 1'b0, ST_BAD_CHAR, 1'b1);
      end else if (produced == 0) begin
        case (sext_cnt)
          2'd2: begin
            push_decoded(sext_acc[11:4], 1'b1, ST_OK, 1'b1);
          end
          2'd3: begin
            push_decoded(sext_acc[17:10], 1'b1, ST_OK, 1'b0);
            push_decoded(sext_acc[9:2], 1'b1, ST_OK, 1'b1);
          end
          2'd1: begin
            push_decoded(8'h00, 1'b0, ST_BAD_LEN, 1'b1);
          end
          default: begin
            push_decoded(8'h00, 1'b0, ST_OK, 1'b1);
          end
        endcase
      end
      sext_acc = '0;
      sext_cnt = '0;
      bad_seen = 1'b0;
    end
  endtask

  // Monitor both channels at each rising edge
  always @(posedge clk_i) begin
    dec_result_t want;
    if (!rst_ni) begin
      sext_acc = '0;
      sext_cnt = '0;
      bad_seen = 1'b0;
    end else begin
      if (in_i.valid && in_i.ready)
        decode_char(in_i.char_code, in_i.end_of_text);

      if (out_i.valid && out_i.ready) begin
        if (decoded_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: result with none expected: %s %02h %s %0d %s %0d %s %0d",
                     $realtime, "byte", out_i.data_byte, "valid", out_i.byte_valid,
                     "status", out_i.status, "final", out_i.final_result);
        end else begin
          want = decoded_q.pop_front();
          if (out_i.data_byte !== want.data_byte ||
              out_i.byte_valid !== want.byte_valid ||
              out_i.status !== want.status ||
              out_i.final_result !== want.final_result) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("%0t: mismatch: expected byte %02h valid %0d status %0d final %0d",
                       $realtime, want.data_byte, want.byte_valid, want.status,
                       want.final_result);
              $display("%0t:           got      byte %02h valid %0d status %0d final %0d",
                       $realtime, out_i.data_byte, out_i.byte_valid, out_i.status,
                       out_i.final_result);
            end
          end
        end
      end
    end
    mismatch_count_o <= err_cnt;
    pending_o        <= decoded_q.size();
  end

endmodule

`default_nettype wire

// ===== tb/tb_base64url_decoder_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_base64url_decoder_top: stimulus and verdict for the base64 decoder
// Sends directed strings that hit every alphabet edge, pad, length and bad
// character case, then random strings, mostly well formed, with bursty input
// and an irregular output stall including one long hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_base64url_decoder_top;
  import b64d_pkg::*;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam int         RAND_ITEMS = 96;
  localparam int         DRAIN_CYC  = 20;

  logic clk_i;
  logic rst_ni;
  int   mismatches;
  int   pending;
  int   burst_left;
  int   rand_items;

  b64d_in_if  in_if ();
  b64d_out_if out_if ();

  base64url_decoder_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  b64d_decode_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_i             (in_if),
    .out_i            (out_if),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  // Clock and reset
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Hard stop
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // Alphabet character for a sextet, standard or URL-safe
  function automatic logic [7:0] sextet_char(input logic [5:0] v, input bit url);
    logic [7:0] c;
    if (v < LOWER_BASE)
      c = 8'h41 + 8'(v);
    else if (v < DIGIT_BASE)
      c = 8'h61 + 8'(v) - LOWER_BASE;
    else if (v < SX_62)
      c = 8'h30 + 8'(v) - DIGIT_BASE;
    else if (v == SX_62)
      c = url ? 8'h2D : 8'h2B;
    else
      c = url ? 8'h5F : 8'h2F;
    return c;
  endfunction

  // One character, sent in bursts with random gaps in between
  task automatic send_char(input logic [7:0] c, input logic eot);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 4);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid       <= 1'b1;
    in_if.char_code   <= c;
    in_if.end_of_text <= eot;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], i == s.len() - 1);
  endtask

  // Output stall pattern, with one long hold-off while input keeps coming
  initial begin
    int cyc;
    cyc = 0;
    out_if.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      cyc++;
      if (cyc >= 40 && cyc < 130)
        out_if.ready <= 1'b0;
      else
        case ((cyc / 50) % 4)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= 1'($urandom_range(0, 1));
          2:       out_if.ready <= (cyc % 4 != 3);
          default: out_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      @(posedge clk_i);
    end
  end

  // Stimulus and verdict
  initial begin
    logic [7:0] str_q[$];
    int         kind;
    int         nsx;
    int         pos;

    in_if.valid       <= 1'b0;
    in_if.char_code   <= 8'h00;
    in_if.end_of_text <= 1'b0;
    burst_left = 0;
    rand_items = 0;
    do @(posedge clk_i); while (!rst_ni);

    // Directed: full group closed by the end item
    send_text("TWFu");
    // Two leftover sextets, string ends on a pad
    send_text("TQ==");
    // URL-safe and standard symbols for 62 and 63
    send_text("-_+/");
    // Three leftover sextets, alphabet edges, nonzero unused bits
    send_text("Az9");
    // Single leftover sextet: length error
    send_text("A");
    // Only a pad: empty string
    send_text("=");
    // Bad character as the end item
    send_char(8'hFF, 1'b1);
    // Bad character mid-string
    send_char(8'h51, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(8'h51, 1'b1);
    // Bad character beats the length error
    send_char(8'h5A, 1'b0);
    send_char(8'h00, 1'b1);

    // Random strings
    while (rand_items < RAND_ITEMS) begin
      str_q.delete();
      kind = $urandom_range(0, 7);
      if (kind == 0) begin
        // noise
        nsx = $urandom_range(1, 6);
        repeat (nsx) str_q.insert(str_q.size(), 8'($urandom_range(0, 255)));
      end else begin
        nsx = $urandom_range(0, 11);
        for (int i = 0; i < nsx; i++) begin
          if ($urandom_range(0, 9) == 0)
            str_q.insert(str_q.size(), PAD_CHAR);
          str_q.insert(str_q.size(),
                       sextet_char(6'($urandom_range(0, 63)), 1'($urandom_range(0, 1))));
        end
        if ($urandom_range(0, 1) == 1)
          while (str_q.size() % 4 != 0) str_q.insert(str_q.size(), PAD_CHAR);
        if (str_q.size() == 0)
          str_q.insert(str_q.size(), PAD_CHAR);
        // occasionally break a well-formed string
        if (kind == 1) begin
          pos = $urandom_range(0, str_q.size() - 1);
          str_q[pos] = 8'($urandom_range(0, 255));
        end
      end
      foreach (str_q[i]) begin
        send_char(str_q[i], i == str_q.size() - 1);
        rand_items++;
      end
    end
    in_if.valid <= 1'b0;

    // Drain
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    if (mismatches == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
